@@ rtl/sadr_pkg.sv @@
// Shared types and constants for the deferred-release stack allocator.
// Used by every module in rtl/; depends on nothing else.
package sadr_pkg;

    localparam int ADDR_W           = 48;
    localparam int SIZE_IN_W        = 63;
    localparam int ALIGN_W          = 4;
    localparam int OUTCOME_W        = 3;
    localparam int HEADER_BYTES     = 16;
    localparam int BUFFER_BYTES_DEF = 65536;
    localparam int ALIGN_MIN        = 3;
    localparam int ALIGN_MAX        = 12;

    localparam logic [OUTCOME_W-1:0] OUT_ALLOC   = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FULL    = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_POP     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_MARK    = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FOREIGN = 3'd4;

    typedef struct packed {
        logic                 kind;
        logic [SIZE_IN_W-1:0] size_bytes;
        logic [ALIGN_W-1:0]   align_log2;
        logic [ADDR_W-1:0]    address;
    } sadr_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]    block_address;
        logic [OUTCOME_W-1:0] outcome;
    } sadr_out_t;

    // Control for the header store: one read and one write port.
    typedef struct packed {
        logic rd_en;
        logic wr_en;      // writes size and link
        logic rel_wr_en;  // writes the released mark
        logic rel_bit;
    } hdr_ctl_t;

endpackage

@@ rtl/sadr_hdr_store.sv @@
// Header store: released marks and size/link words, one entry per 8-byte granule.
// Two synchronous memories with registered reads; uses sadr_pkg.
module sadr_hdr_store
    import sadr_pkg::*;
#(
    parameter int SLOT_COUNT = BUFFER_BYTES_DEF / 8,
    parameter int SLOT_W     = $clog2(BUFFER_BYTES_DEF / 8),
    parameter int OFF_W      = $clog2(BUFFER_BYTES_DEF) + 1
) (
    input  logic              aclk,
    input  hdr_ctl_t          ctl,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic [SLOT_W-1:0] wr_slot,
    input  logic [OFF_W-1:0]  wr_size,
    input  logic [OFF_W-1:0]  wr_link,
    output logic              rd_rel,
    output logic [OFF_W-1:0]  rd_size,
    output logic [OFF_W-1:0]  rd_link
);

    logic                   rel_mem  [SLOT_COUNT];
    logic [2*OFF_W-1:0]     data_mem [SLOT_COUNT];
    logic                   rd_rel_reg;
    logic [2*OFF_W-1:0]     rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.rel_wr_en) begin
            rel_mem[wr_slot] <= ctl.rel_bit;
        end
        if (ctl.wr_en) begin
            data_mem[wr_slot] <= {wr_size, wr_link};
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_rel_reg  <= rel_mem[rd_slot];
            rd_data_reg <= data_mem[rd_slot];
        end
    end

    assign rd_rel  = rd_rel_reg;
    assign rd_size = rd_data_reg[2*OFF_W-1:OFF_W];
    assign rd_link = rd_data_reg[OFF_W-1:0];

endmodule

@@ rtl/sadr_ctrl.sv @@
// Sequencer of the allocator: placement arithmetic, release classification and
// the pop walk over released headers. Uses sadr_pkg; drives sadr_hdr_store.
module sadr_ctrl
    import sadr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    parameter int SLOT_W       = $clog2(BUFFER_BYTES_DEF / 8),
    parameter int OFF_W        = $clog2(BUFFER_BYTES_DEF) + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [ADDR_W-1:0] base,
    input  logic              in_valid,
    output logic              in_ready,
    input  sadr_in_t          in_data,
    output logic              res_valid,
    input  logic              res_ready,
    output sadr_out_t         res_data,
    output hdr_ctl_t          hdr_ctl,
    output logic [SLOT_W-1:0] hdr_rd_slot,
    output logic [SLOT_W-1:0] hdr_wr_slot,
    output logic [OFF_W-1:0]  hdr_wr_size,
    output logic [OFF_W-1:0]  hdr_wr_link,
    input  logic              hdr_rd_rel,
    input  logic [OFF_W-1:0]  hdr_rd_size,
    input  logic [OFF_W-1:0]  hdr_rd_link
);

    localparam int ABS_W = ADDR_W + 2;
    localparam int SUM_W = SIZE_IN_W + 1;
    localparam int AL_W  = ALIGN_MAX + 1;
    localparam logic [OFF_W-1:0] BUF_OFF = OFF_W'(BUFFER_BYTES);
    localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUR,
        ST_ALIGN,
        ST_ADJ,
        ST_FIT,
        ST_CLASS,
        ST_WALK_CHK,
        ST_WALK_RD,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    sadr_in_t           item_reg, item_next;
    logic [ABS_W-1:0]   cur_reg, cur_next;
    logic [ABS_W-1:0]   aligned0_reg, aligned0_next;
    logic [AL_W-1:0]    adj_reg, adj_next;
    logic [ABS_W-1:0]   aligned_reg, aligned_next;
    logic [OFF_W-1:0]   walk_reg, walk_next;
    logic [OFF_W-1:0]   last_block_reg, last_block_next;
    sadr_out_t          res_reg, res_next;

    logic [ABS_W-1:0]   base_abs;
    logic [ALIGN_W-1:0] lg;
    logic [AL_W-1:0]    a_m1;
    logic [AL_W-1:0]    pad;
    logic [SUM_W-1:0]   fit_sum;
    logic [SUM_W-1:0]   end_abs;
    logic [ABS_W-1:0]   alloc_off;
    logic [ABS_W-1:0]   p_abs;
    logic [ABS_W-1:0]   p_off;
    logic               is_top;
    logic               foreign;
    logic               walk_ok;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
        logic [OFF_W-1:0] d;
        d = off - HDR_OFF;
        return d[SLOT_W+2:3];
    endfunction

    assign base_abs = {2'b00, base};

    always_comb begin
        if (item_reg.align_log2 < ALIGN_W'(ALIGN_MIN)) begin
            lg = ALIGN_W'(ALIGN_MIN);
        end else if (item_reg.align_log2 > ALIGN_W'(ALIGN_MAX)) begin
            lg = ALIGN_W'(ALIGN_MAX);
        end else begin
            lg = item_reg.align_log2;
        end
    end

    assign a_m1      = (AL_W'(1) << lg) - AL_W'(1);
    assign pad       = (AL_W'(0) - cur_reg[AL_W-1:0]) & a_m1;
    assign fit_sum   = SUM_W'(aligned_reg) + SUM_W'(item_reg.size_bytes);
    assign end_abs   = SUM_W'(base_abs) + SUM_W'(BUFFER_BYTES);
    assign alloc_off = aligned_reg - base_abs;
    assign p_abs     = {2'b00, item_reg.address};
    assign p_off     = p_abs - base_abs;
    assign is_top    = (last_block_reg != '0) && (p_abs == base_abs + ABS_W'(last_block_reg));
    assign foreign   = (p_abs < base_abs) || (p_off >= ABS_W'(BUFFER_BYTES))
                       || (p_off < ABS_W'(HEADER_BYTES));
    assign walk_ok   = (walk_reg != '0) && (walk_reg < BUF_OFF) && (walk_reg >= HDR_OFF);

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        aligned0_next   = aligned0_reg;
        adj_next        = adj_reg;
        aligned_next    = aligned_reg;
        walk_next       = walk_reg;
        last_block_next = last_block_reg;
        res_next        = res_reg;
        hdr_ctl         = '0;
        hdr_rd_slot     = slot_of(last_block_reg);
        hdr_wr_slot     = slot_of(alloc_off[OFF_W-1:0]);
        hdr_wr_size     = item_reg.size_bytes[OFF_W-1:0];
        hdr_wr_link     = last_block_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    // The top header is fetched for both kinds of item.
                    item_next     = in_data;
                    hdr_ctl.rd_en = 1'b1;
                    state_next    = in_data.kind ? ST_CLASS : ST_CUR;
                end
            end
            ST_CUR: begin
                if (last_block_reg == '0) begin
                    cur_next = base_abs;
                end else begin
                    cur_next = base_abs + ABS_W'(last_block_reg) + ABS_W'(hdr_rd_size);
                end
                state_next = ST_ALIGN;
            end
            ST_ALIGN: begin
                aligned0_next = (cur_reg + ABS_W'(a_m1)) & ~ABS_W'(a_m1);
                // At least a header's worth of bytes must lie below the block.
                if (lg == ALIGN_W'(ALIGN_MIN)) begin
                    adj_next = AL_W'(HEADER_BYTES);
                end else if (pad < AL_W'(HEADER_BYTES)) begin
                    adj_next = a_m1 + AL_W'(1);
                end else begin
                    adj_next = '0;
                end
                state_next = ST_ADJ;
            end
            ST_ADJ: begin
                aligned_next = aligned0_reg + ABS_W'(adj_reg);
                state_next   = ST_FIT;
            end
            ST_FIT: begin
                if (fit_sum >= end_abs) begin
                    res_next.block_address = '0;
                    res_next.outcome       = OUT_FULL;
                end else begin
                    hdr_ctl.wr_en          = 1'b1;
                    hdr_ctl.rel_wr_en      = 1'b1;
                    hdr_ctl.rel_bit        = 1'b0;
                    last_block_next        = alloc_off[OFF_W-1:0];
                    res_next.block_address = aligned_reg[ADDR_W-1:0];
                    res_next.outcome       = OUT_ALLOC;
                end
                state_next = ST_DONE;
            end
            ST_CLASS: begin
                res_next.block_address = '0;
                if (is_top) begin
                    walk_next  = hdr_rd_link;
                    state_next = ST_WALK_CHK;
                end else if (foreign) begin
                    res_next.outcome = OUT_FOREIGN;
                    state_next       = ST_DONE;
                end else begin
                    hdr_ctl.rel_wr_en = 1'b1;
                    hdr_ctl.rel_bit   = 1'b1;
                    hdr_wr_slot       = slot_of(p_off[OFF_W-1:0]);
                    res_next.outcome  = OUT_MARK;
                    state_next        = ST_DONE;
                end
            end
            ST_WALK_CHK: begin
                if (walk_ok) begin
                    hdr_ctl.rd_en = 1'b1;
                    hdr_rd_slot   = slot_of(walk_reg);
                    state_next    = ST_WALK_RD;
                end else begin
                    last_block_next  = walk_reg;
                    res_next.outcome = OUT_POP;
                    state_next       = ST_DONE;
                end
            end
            ST_WALK_RD: begin
                if (hdr_rd_rel) begin
                    walk_next  = hdr_rd_link;
                    state_next = ST_WALK_CHK;
                end else begin
                    last_block_next  = walk_reg;
                    res_next.outcome = OUT_POP;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_block_reg <= '0;
        end else begin
            state_reg      <= state_next;
            last_block_reg <= last_block_next;
            item_reg       <= item_next;
            cur_reg        <= cur_next;
            aligned0_reg   <= aligned0_next;
            adj_reg        <= adj_next;
            aligned_reg    <= aligned_next;
            walk_reg       <= walk_next;
            res_reg        <= res_next;
        end
    end

    // No item is taken while reset is held.
    assign in_ready  = aresetn && (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = res_reg;

    // Reads and writes of the store never share a cycle, so no forwarding is needed.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(hdr_ctl.rd_en && (hdr_ctl.wr_en || hdr_ctl.rel_wr_en)))
        else $error("header store read and write in the same cycle");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && res_valid))
        else $error("input taken while a result is pending");

    a_top_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_block_reg == '0) || ((last_block_reg >= HDR_OFF) && (last_block_reg < BUF_OFF)))
        else $error("top block offset outside the buffer");

    a_top_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_block_reg != $past(last_block_reg)) |->
            ($past(state_reg) == ST_FIT || $past(state_reg) == ST_WALK_CHK
             || $past(state_reg) == ST_WALK_RD))
        else $error("top block changed outside allocate or pop");

endmodule

@@ rtl/stack_allocator_deferred_release_top.sv @@
// Stack allocator with deferred release over a scratch buffer: top level.
// Holds the base register and the result register; uses sadr_pkg, sadr_ctrl
// and sadr_hdr_store.
//
// Usage: items arrive on s_valid/s_ready/s_data (kind, size_bytes, align_log2,
// address) and each gives exactly one result on m_valid/m_ready/m_data
// (block_address, outcome). The buffer base is written over cfg_valid/cfg_ready/
// cfg_data, which is ready whenever reset is released; write it only while no
// item is in flight. One item is worked on at a time. After acceptance an
// allocate passes the states CUR, ALIGN, ADJ and FIT, a mark or a foreign
// release passes CLASS, and a pop passes CLASS and then walks the released
// blocks below the top, before DONE raises the result. The pop walk reads
// one header at a time: WALK_CHK issues a read through the registered read
// port of the header store and WALK_RD checks its released mark, so the
// pop time grows with the number of released blocks popped with the top.
// The next item can be accepted in the cycle after the previous result
// enters the output register.
// Reset clears the top-block pointer and the base; the header store needs
// no clearing pass, since every header on the live chain is written by the
// allocate that created it. When m_ready stays low, one result waits in the
// output register, a second waits inside the sequencer, and s_ready stays low.
module stack_allocator_deferred_release_top
    import sadr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sadr_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sadr_out_t         m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam int SLOT_COUNT = BUFFER_BYTES / 8;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int OFF_W      = $clog2(BUFFER_BYTES) + 1;

    logic [ADDR_W-1:0] buffer_base_reg;
    logic              m_valid_reg;
    sadr_out_t         m_data_reg;

    logic              res_valid;
    logic              res_ready;
    sadr_out_t         res_data;
    hdr_ctl_t          hdr_ctl;
    logic [SLOT_W-1:0] hdr_rd_slot;
    logic [SLOT_W-1:0] hdr_wr_slot;
    logic [OFF_W-1:0]  hdr_wr_size;
    logic [OFF_W-1:0]  hdr_wr_link;
    logic              hdr_rd_rel;
    logic [OFF_W-1:0]  hdr_rd_size;
    logic [OFF_W-1:0]  hdr_rd_link;
    logic [ADDR_W-1:0] base;

    assign cfg_ready = aresetn;
    // The low three bits of the base are ignored.
    assign base      = {buffer_base_reg[ADDR_W-1:3], 3'b000};
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_base_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                buffer_base_reg <= cfg_data;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
                m_data_reg  <= res_data;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    sadr_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .SLOT_W       (SLOT_W),
        .OFF_W        (OFF_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .base        (base),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .hdr_ctl     (hdr_ctl),
        .hdr_rd_slot (hdr_rd_slot),
        .hdr_wr_slot (hdr_wr_slot),
        .hdr_wr_size (hdr_wr_size),
        .hdr_wr_link (hdr_wr_link),
        .hdr_rd_rel  (hdr_rd_rel),
        .hdr_rd_size (hdr_rd_size),
        .hdr_rd_link (hdr_rd_link)
    );

    sadr_hdr_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W),
        .OFF_W      (OFF_W)
    ) u_hdr_store (
        .aclk    (aclk),
        .ctl     (hdr_ctl),
        .rd_slot (hdr_rd_slot),
        .wr_slot (hdr_wr_slot),
        .wr_size (hdr_wr_size),
        .wr_link (hdr_wr_link),
        .rd_rel  (hdr_rd_rel),
        .rd_size (hdr_rd_size),
        .rd_link (hdr_rd_link)
    );

endmodule

@@ tb/tb_stack_allocator_deferred_release_top.sv @@
`timescale 1ns / 1ps
// Testbench for stack_allocator_deferred_release_top: a directed table, then random
// allocate and release traffic under five buffer bases, checked against a local predictor.
// Depends on rtl/sadr_pkg.sv and the top level of the allocator.
module tb_stack_allocator_deferred_release_top;
    import sadr_pkg::*;

    localparam int BUF_BYTES      = BUFFER_BYTES_DEF;
    localparam int SLOTS          = BUF_BYTES / 8;
    localparam int IDLE_PCT       = 29;
    localparam int RAND_PER_PHASE = 270;
    localparam int PHASES         = 5;
    localparam int TAIL_CYCLES    = 60;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        sadr_in_t  item;
        bit        typed;
        sadr_out_t want;
    } dir_row_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    sadr_in_t          s_data    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    sadr_out_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data  = '0;

    // Predictor state: one header per 8-byte granule, plus the top block and the base.
    bit          mark_bit [SLOTS];
    logic [62:0] blk_len  [SLOTS];
    logic [16:0] blk_prev [SLOTS];
    logic [16:0] top_blk = '0;
    logic [47:0] base_q  = '0;

    sadr_out_t pending_results [$];
    dir_row_t  dir_rows [$];
    bit        quiet    = 1'b0;
    int        errors   = 0;
    int        n_sent   = 0;
    int        n_done   = 0;
    int        cycles   = 0;
    int        outcome_seen [5] = '{default: 0};

    stack_allocator_deferred_release_top #(
        .BUFFER_BYTES(BUF_BYTES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int hdr_slot(logic [63:0] off);
        logic [63:0] s;
        s = (off - 64'(HEADER_BYTES)) >> 3;
        return (s < SLOTS) ? int'(s) : SLOTS - 1;
    endfunction

    function automatic logic [63:0] buf_start();
        return {16'b0, base_q & ~48'h7};
    endfunction

    // Works out the result of one item and advances the header state.
    function automatic sadr_out_t alloc_predict(sadr_in_t it);
        sadr_out_t   r;
        logic [63:0] lo, hi, cur, a, aligned, pad, size, off, p, nxt;
        int          lg, guard, s;
        lo = buf_start();
        hi = lo + 64'(BUF_BYTES);
        r = '0;
        if (it.kind == 1'b0) begin
            size = {1'b0, it.size_bytes};
            lg = int'(it.align_log2);
            if (lg < ALIGN_MIN) lg = ALIGN_MIN;
            if (lg > ALIGN_MAX) lg = ALIGN_MAX;
            a = 64'd1 << lg;
            if (top_blk == 0) cur = lo;
            else cur = lo + 64'(top_blk) + {1'b0, blk_len[hdr_slot(64'(top_blk))]};
            aligned = (cur + a - 1) & ~(a - 1);
            pad = aligned - cur;
            if (pad < HEADER_BYTES) aligned += (64'(HEADER_BYTES) - pad + a - 1) / a * a;
            if (aligned + size >= hi) begin
                r.outcome = OUT_FULL;
            end else begin
                off = aligned - lo;
                s = hdr_slot(off);
                mark_bit[s] = 1'b0;
                blk_len[s] = it.size_bytes;
                blk_prev[s] = top_blk;
                top_blk = off[16:0];
                r.block_address = aligned[47:0];
                r.outcome = OUT_ALLOC;
            end
        end else begin
            p = {16'b0, it.address};
            if (top_blk != 0 && p == lo + 64'(top_blk)) begin
                // Pop the top, then every released block directly beneath it.
                nxt = 64'(blk_prev[hdr_slot(64'(top_blk))]);
                guard = 0;
                while (nxt != 0 && nxt < BUF_BYTES && nxt >= HEADER_BYTES &&
                       mark_bit[hdr_slot(nxt)] && guard < SLOTS) begin
                    nxt = 64'(blk_prev[hdr_slot(nxt)]);
                    guard++;
                end
                top_blk = nxt[16:0];
                r.outcome = OUT_POP;
            end else if (p < lo || p >= hi || p - lo < HEADER_BYTES) begin
                r.outcome = OUT_FOREIGN;
            end else begin
                mark_bit[hdr_slot(p - lo)] = 1'b1;
                r.outcome = OUT_MARK;
            end
        end
        return r;
    endfunction

    // Address of the block that lies depth links below the top, or of the bottom block if the chain is shorter.
    function automatic logic [47:0] chain_addr(int depth);
        logic [16:0] off;
        logic [63:0] abs_addr;
        int          i;
        off = top_blk;
        for (i = 0; i < depth; i++) begin
            if (blk_prev[hdr_slot(64'(off))] == 0) break;
            off = blk_prev[hdr_slot(64'(off))];
        end
        abs_addr = buf_start() + 64'(off);
        return abs_addr[47:0];
    endfunction

    // Mostly well-formed traffic on the live stack, with a share of stray addresses.
    function automatic sadr_in_t random_item();
        sadr_in_t    it;
        int          r, sel;
        logic [63:0] lo, v;
        lo = buf_start();
        v = {$urandom, $urandom};
        it.size_bytes = v[62:0];
        it.align_log2 = 4'($urandom_range(0, 15));
        v = {$urandom, $urandom};
        it.address = v[47:0];
        r = $urandom_range(0, 99);
        if (r < 48) begin
            it.kind = 1'b0;
            sel = $urandom_range(0, 99);
            if (sel < 70) it.size_bytes = 63'($urandom_range(0, 64));
            else if (sel < 90) it.size_bytes = 63'($urandom_range(0, 3000));
            else if (sel < 97) it.size_bytes = 63'($urandom_range(0, 70000));
            if ($urandom_range(0, 9) != 0) it.align_log2 = 4'($urandom_range(3, 6));
        end else begin
            it.kind = 1'b1;
            if (r < 70 && top_blk != 0) begin
                it.address = chain_addr(0);
            end else if (r < 88 && top_blk != 0) begin
                it.address = chain_addr($urandom_range(1, 6)) + 48'($urandom_range(0, 7));
            end else begin
                sel = $urandom_range(0, 2);
                if (sel == 1) begin
                    v = lo + 64'($urandom_range(0, BUF_BYTES + 4096));
                    it.address = v[47:0];
                end else if (sel == 2) begin
                    v = lo + 64'($urandom_range(0, HEADER_BYTES));
                    it.address = v[47:0];
                end
            end
        end
        return it;
    endfunction

    task automatic add_row(bit k, logic [62:0] sz, logic [3:0] al, logic [47:0] ad,
                           bit typed, logic [47:0] exp_addr, logic [2:0] exp_out);
        dir_row_t row;
        row.item.kind = k;
        row.item.size_bytes = sz;
        row.item.align_log2 = al;
        row.item.address = ad;
        row.typed = typed;
        row.want.block_address = exp_addr;
        row.want.outcome = exp_out;
        dir_rows.push_back(row);
    endtask

    task automatic send_item(sadr_in_t it, bit typed, sadr_out_t want);
        sadr_out_t predicted;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = alloc_predict(it);
        pending_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_base(logic [47:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        base_q = v;
    endtask

    always @(posedge aclk) begin
        m_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : result_check
        sadr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending: expected none, actual %h",
                         $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                n_done++;
                if (want.outcome <= OUT_FOREIGN) outcome_seen[want.outcome]++;
                if (m_data.outcome !== want.outcome) begin
                    $display("%0t: outcome mismatch: expected %0d, actual %0d",
                             $time, want.outcome, m_data.outcome);
                    errors++;
                end
                if (m_data.block_address !== want.block_address) begin
                    $display("%0t: block_address mismatch: expected %h, actual %h",
                             $time, want.block_address, m_data.block_address);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("tb_stack_allocator_deferred_release_top: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int          ph, i;
        logic [47:0] next_base;
        // Reset base is zero; typed rows follow directly from that layout.
        add_row(1'b1, '0, 4'd3, 48'd0, 1, '0, OUT_FOREIGN);
        add_row(1'b1, '0, 4'd3, 48'd15, 1, '0, OUT_FOREIGN);
        add_row(1'b1, '0, 4'd3, 48'd65536, 1, '0, OUT_FOREIGN);
        add_row(1'b1, '0, 4'd3, 48'hFFFF_FFFF_FFFF, 1, '0, OUT_FOREIGN);
        add_row(1'b0, 63'h7FFF_FFFF_FFFF_FFFF, 4'd12, '0, 1, '0, OUT_FULL);
        add_row(1'b0, 63'd0, 4'd3, '0, 1, 48'd16, OUT_ALLOC);
        add_row(1'b0, 63'd0, 4'd0, '0, 1, 48'd32, OUT_ALLOC);
        add_row(1'b0, 63'd5, 4'd15, '0, 1, 48'd4096, OUT_ALLOC);
        add_row(1'b0, 63'd100, 4'd4, '0, 0, '0, OUT_ALLOC);
        // Misaligned mark, mark below the top, and a mark on a header never written.
        add_row(1'b1, '0, 4'd3, 48'd35, 1, '0, OUT_MARK);
        add_row(1'b1, '0, 4'd3, 48'd4096, 1, '0, OUT_MARK);
        add_row(1'b1, '0, 4'd3, 48'd20000, 1, '0, OUT_MARK);
        // Popping the top also takes the two marked blocks beneath it.
        add_row(1'b1, '0, 4'd3, 48'd4128, 1, '0, OUT_POP);
        add_row(1'b0, 63'd1000, 4'd3, '0, 0, '0, OUT_ALLOC);
        add_row(1'b0, 63'd65536, 4'd3, '0, 1, '0, OUT_FULL);
        add_row(1'b1, '0, 4'd3, 48'd16, 0, '0, OUT_MARK);
        add_row(1'b1, '0, 4'd3, 48'd32, 1, '0, OUT_POP);
        add_row(1'b0, 63'h4000_0000_0000_0000, 4'd5, '0, 1, '0, OUT_FULL);
        // Exactly at the buffer end is full; one byte less fits.
        add_row(1'b0, 63'd65520, 4'd3, '0, 1, '0, OUT_FULL);
        add_row(1'b0, 63'd65519, 4'd3, '0, 1, 48'd16, OUT_ALLOC);
        add_row(1'b0, 63'd0, 4'd3, '0, 0, '0, OUT_FULL);
        add_row(1'b1, '0, 4'd3, 48'd16, 1, '0, OUT_POP);
        // Release with an empty stack cannot hit the top, so it only marks.
        add_row(1'b1, '0, 4'd3, 48'd16, 1, '0, OUT_MARK);
        add_row(1'b0, 63'd7, 4'd12, '0, 1, 48'd4096, OUT_ALLOC);
        add_row(1'b1, '0, 4'd3, 48'd4096, 1, '0, OUT_POP);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: next_base = 48'h0000_0000_1003;
                    2: next_base = 48'hFFFF_FFFF_FFFF;
                    3: next_base = 48'({$urandom, $urandom});
                    default: next_base = 48'h0;
                endcase
                write_base(next_base);
            end
            quiet = (ph == 3);
            for (i = 0; i < RAND_PER_PHASE; i++) begin
                if (ph == 1 && i == RAND_PER_PHASE / 2) drain_results();
                send_item(random_item(), 1'b0, '0);
            end
        end

        drain_results();
        quiet = 1'b0;
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("Sent %0d items under %0d buffer bases; %0d results checked.",
                 n_sent, PHASES, n_done);
        $display("Outcomes: %0d allocated, %0d full, %0d popped, %0d marked, %0d foreign.",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4]);
        if (errors == 0) begin
            $display("tb_stack_allocator_deferred_release_top: PASS");
        end else begin
            $display("tb_stack_allocator_deferred_release_top: FAIL");
        end
        $finish;
    end

endmodule
